// File: hdl/position_frame_parser_defines.svh
// assertion helpers shared by the parser modules
`ifndef POSITION_FRAME_PARSER_DEFINES_SVH
`define POSITION_FRAME_PARSER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pfp_pkg.sv
`timescale 1ns / 1ps
package pfp_pkg;

  localparam int WIN_LEN = 16;
  localparam int FILL_W = 5;
  localparam int SYNC_LEN = 8;

  localparam logic [8*SYNC_LEN-1:0] SYNC_TEXT = 64'h414C_4C52_4541_4459;
  localparam logic [7:0] CLUTCH_MARK = 8'd101;
  localparam logic [7:0] POS_MARK = 8'd97;

  typedef enum logic [1:0] {
    KIND_SYNC     = 2'd0,
    KIND_CLUTCH   = 2'd1,
    KIND_POSITION = 2'd2
  } frame_kind_t;

  typedef logic [WIN_LEN-1:0][7:0] window_t;

  typedef struct packed {
    frame_kind_t kind;
    window_t     win;
  } frame_entry_t;

  typedef struct packed {
    logic         valid;
    frame_entry_t entry;
  } queue_item_t;

endpackage

// File: hdl/pfp_rx_if.sv
`timescale 1ns / 1ps
interface pfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/pfp_frame_if.sv
`timescale 1ns / 1ps
interface pfp_frame_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic               clutch_on;
  logic signed [23:0] master_translation;
  logic signed [23:0] master_twist;
  logic signed [23:0] slave_translation;
  logic signed [23:0] slave_twist;

  modport source (
    output valid, output frame_kind, output clutch_on,
    output master_translation, output master_twist,
    output slave_translation, output slave_twist,
    input ready
  );
  modport sink (
    input valid, input frame_kind, input clutch_on,
    input master_translation, input master_twist,
    input slave_translation, input slave_twist,
    output ready
  );
endinterface

// File: hdl/pfp_queue.sv
`timescale 1ns / 1ps
`include "position_frame_parser_defines.svh"
module pfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  pfp_pkg::queue_item_t push,
  output logic                full,
  output pfp_pkg::queue_item_t head,
  input  logic                pop
);
  import pfp_pkg::*;

  frame_entry_t slots [2];
  logic [1:0]   count;
  logic         wr_ptr;
  logic         rd_ptr;
  logic         do_push;
  logic         do_pop;

  assign full = (count == 2'd2);
  assign do_push = push.valid && !full;
  assign do_pop = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `PFP_ASSERT(a_no_overflow, !(push.valid && full), "frame pushed into a full queue")
  `PFP_ASSERT(a_count_range, count <= 2'd2, "queue count out of range")
  `PFP_ASSERT_NEXT(a_push_seen, do_push && !do_pop, head.valid, "pushed frame not visible")
endmodule

// File: hdl/pfp_front.sv
`timescale 1ns / 1ps
`include "position_frame_parser_defines.svh"
module pfp_front (
  input  logic                 clk,
  input  logic                 rst,
  pfp_rx_if.sink               rx,
  output pfp_pkg::queue_item_t push,
  input  logic                 full
);
  import pfp_pkg::*;

  window_t           win;
  window_t           win_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_inc;
  logic              accept;
  logic              win_full;
  logic              is_sync;
  logic              is_clutch;
  logic              is_pos;
  frame_kind_t       kind;

  assign rx.ready = !full;
  assign accept = rx.valid && rx.ready;

  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[WIN_LEN-1] = rx.rx_byte;
  end

  assign fill_inc = (fill == FILL_W'(WIN_LEN)) ? fill : fill + FILL_W'(1);
  assign win_full = (fill_inc == FILL_W'(WIN_LEN));

  always_comb begin
    is_sync = 1'b1;
    for (int i = 0; i < SYNC_LEN; i++) begin
      if (win_next[i] != SYNC_TEXT[8*(SYNC_LEN-1-i) +: 8]) begin
        is_sync = 1'b0;
      end
    end
  end

  assign is_clutch = (win_next[0] == CLUTCH_MARK) &&
                     (win_next[4] == CLUTCH_MARK + 8'd1) &&
                     (win_next[8] == CLUTCH_MARK + 8'd2) &&
                     (win_next[12] == CLUTCH_MARK + 8'd3);
  assign is_pos = (win_next[0] == POS_MARK) &&
                  (win_next[4] == POS_MARK + 8'd1) &&
                  (win_next[8] == POS_MARK + 8'd2) &&
                  (win_next[12] == POS_MARK + 8'd3);

  always_comb begin
    if (is_sync) begin
      kind = KIND_SYNC;
    end else if (is_clutch) begin
      kind = KIND_CLUTCH;
    end else begin
      kind = KIND_POSITION;
    end
  end

  assign push.valid = accept && win_full && (is_sync || is_clutch || is_pos);
  assign push.entry.kind = kind;
  assign push.entry.win = win_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= push.valid ? '0 : fill_inc;
    end
  end

  `PFP_ASSERT_NEXT(a_fill_cleared, push.valid, fill == '0, "window not emptied after a frame")
  `PFP_ASSERT(a_push_needs_full, !push.valid || win_full, "frame reported on a partial window")
endmodule

// File: hdl/pfp_back.sv
`timescale 1ns / 1ps
`include "position_frame_parser_defines.svh"
module pfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pfp_pkg::queue_item_t head,
  output logic                 pop,
  pfp_frame_if.source          frame
);
  import pfp_pkg::*;

  logic out_valid;
  logic is_clutch;
  logic is_pos;

  assign pop = head.valid && (!out_valid || frame.ready);
  assign frame.valid = out_valid;
  assign is_clutch = (head.entry.kind == KIND_CLUTCH);
  assign is_pos = (head.entry.kind == KIND_POSITION);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  // in a position frame, big-endian 24-bit counts follow each marker
  always_ff @(posedge clk) begin
    if (pop) begin
      frame.frame_kind <= head.entry.kind;
      frame.clutch_on <= is_clutch && (head.entry.win[1] != 8'd0);
      frame.master_translation <= is_pos ?
        {head.entry.win[1], head.entry.win[2], head.entry.win[3]} : 24'sd0;
      frame.master_twist <= is_pos ?
        {head.entry.win[5], head.entry.win[6], head.entry.win[7]} : 24'sd0;
      frame.slave_translation <= is_pos ?
        {head.entry.win[9], head.entry.win[10], head.entry.win[11]} : 24'sd0;
      frame.slave_twist <= is_pos ?
        {head.entry.win[13], head.entry.win[14], head.entry.win[15]} : 24'sd0;
    end
  end

  `PFP_ASSERT_NEXT(a_pop_loads, pop, out_valid, "popped frame not presented")
  `PFP_ASSERT(a_pop_has_data, !pop || head.valid, "pop from an empty queue")
endmodule

// File: hdl/position_frame_parser.sv
`timescale 1ns / 1ps
// a finished frame is pushed into the queue, then popped into the output register
// throughput: one byte per cycle while the queue is not full; a two-entry queue between
// classifier and output register lets the byte side keep running while a finished frame waits
// reset: clears the window fill count, the queue and the output valid; window bytes keep value
module position_frame_parser (
  input  logic        clk,
  input  logic        rst,
  pfp_rx_if.sink      rx,
  pfp_frame_if.source frame
);
  import pfp_pkg::*;

  queue_item_t push;
  queue_item_t head;
  logic        full;
  logic        pop;

  pfp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .push (push),
    .full (full)
  );

  pfp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  pfp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .frame (frame)
  );
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pfp_pkg::*;

  typedef logic [7:0] frame_bytes_t [WIN_LEN];

  typedef struct packed {
    frame_kind_t kind;
    logic        clutch;
    logic [23:0] m_trans;
    logic [23:0] m_twist;
    logic [23:0] s_trans;
    logic [23:0] s_twist;
  } frame_fields_t;

  logic clk = 1'b0;
  logic rst;

  pfp_rx_if    rx_ch();
  pfp_frame_if frame_ch();

  position_frame_parser dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .frame (frame_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]    win_bytes [WIN_LEN];
  int unsigned   win_count;
  frame_fields_t expected_frames [$];
  int unsigned   error_count;
  int unsigned   bytes_sent;
  int unsigned   src_idle_pct;
  int unsigned   snk_stall_pct;
  int unsigned   hold_left;

  task automatic flag_error(input string msg);
    $display("error: %s", msg);
    error_count++;
  endtask

  function automatic logic markers_ok(input logic [7:0] first);
    return win_bytes[0] == first && win_bytes[4] == first + 8'd1 &&
           win_bytes[8] == first + 8'd2 && win_bytes[12] == first + 8'd3;
  endfunction

  // window model: shift in one byte, classify once the window is full
  function automatic void shift_in_byte(input logic [7:0] b);
    frame_fields_t r;
    logic          hit;
    logic          sync_ok;
    for (int i = 0; i < WIN_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[WIN_LEN - 1] = b;
    if (win_count < WIN_LEN) win_count++;
    if (win_count < WIN_LEN) return;
    r = '0;
    hit = 1'b1;
    sync_ok = 1'b1;
    for (int i = 0; i < SYNC_LEN; i++) begin
      if (win_bytes[i] != SYNC_TEXT[8 * (SYNC_LEN - 1 - i) +: 8]) sync_ok = 1'b0;
    end
    if (sync_ok) begin
      r.kind = KIND_SYNC;
    end else if (markers_ok(CLUTCH_MARK)) begin
      r.kind = KIND_CLUTCH;
      r.clutch = win_bytes[1] != 8'd0;
    end else if (markers_ok(POS_MARK)) begin
      r.kind = KIND_POSITION;
      r.m_trans = {win_bytes[1], win_bytes[2], win_bytes[3]};
      r.m_twist = {win_bytes[5], win_bytes[6], win_bytes[7]};
      r.s_trans = {win_bytes[9], win_bytes[10], win_bytes[11]};
      r.s_twist = {win_bytes[13], win_bytes[14], win_bytes[15]};
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      expected_frames.push_back(r);
      win_count = 0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    shift_in_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_bytes_t f);
    for (int i = 0; i < WIN_LEN; i++) send_byte(f[i]);
  endtask

  function automatic frame_bytes_t make_frame(input frame_kind_t k);
    frame_bytes_t f;
    logic [7:0]   mark;
    for (int i = 0; i < WIN_LEN; i++) f[i] = 8'($urandom);
    if (k == KIND_SYNC) begin
      for (int i = 0; i < SYNC_LEN; i++) f[i] = SYNC_TEXT[8 * (SYNC_LEN - 1 - i) +: 8];
    end else begin
      mark = (k == KIND_CLUTCH) ? CLUTCH_MARK : POS_MARK;
      for (int i = 0; i < 4; i++) f[4 * i] = mark + 8'(i);
      if (k == KIND_CLUTCH && $urandom_range(1)) f[1] = 8'd0;
    end
    return f;
  endfunction

  function automatic frame_bytes_t position_frame(input logic [23:0] v0, input logic [23:0] v1,
                                                  input logic [23:0] v2, input logic [23:0] v3);
    frame_bytes_t f;
    logic [23:0]  vals [4];
    f = make_frame(KIND_POSITION);
    vals = '{v0, v1, v2, v3};
    for (int i = 0; i < 4; i++) {f[4 * i + 1], f[4 * i + 2], f[4 * i + 3]} = vals[i];
    return f;
  endfunction

  // no result while the window fills, then a sync frame with 0x00 / 0xff tail bytes
  task automatic test_sync_frame();
    frame_bytes_t f;
    f = make_frame(KIND_SYNC);
    for (int i = SYNC_LEN; i < WIN_LEN; i++) f[i] = (i % 2) ? 8'hFF : 8'h00;
    send_frame(f);
  endtask

  task automatic test_clutch_flag();
    frame_bytes_t f;
    f = make_frame(KIND_CLUTCH);
    f[1] = 8'h00;
    send_frame(f);
    f = make_frame(KIND_CLUTCH);
    f[1] = 8'h80;
    send_frame(f);
  endtask

  task automatic test_position_extremes();
    send_frame(position_frame(24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF));
  endtask

  // receiver holds off while frames keep coming, so the output queue fills
  task automatic test_output_backpressure();
    snk_stall_pct = 0;
    src_idle_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 8; i++) send_frame(make_frame(KIND_POSITION));
  endtask

  task automatic test_random_stream(input int unsigned n_bytes, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned  start;
    int unsigned  pick;
    int unsigned  idx;
    frame_bytes_t f;
    frame_kind_t  k;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      k = frame_kind_t'($urandom_range(2));
      if (pick < 70) begin
        send_frame(make_frame(k));
      end else if (pick < 82) begin
        // one marker or sync character flipped
        f = make_frame(k);
        idx = (k == KIND_SYNC) ? $urandom_range(SYNC_LEN - 1) : 4 * $urandom_range(3);
        f[idx] = f[idx] ^ 8'(1 << $urandom_range(7));
        send_frame(f);
      end else begin
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(2) == 0) send_byte(8'($urandom_range(96, 105)));
          else send_byte(8'($urandom));
        end
      end
    end
  endtask

  initial begin
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        frame_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        frame_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    frame_fields_t want;
    if (!rst && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        flag_error($sformatf("frame of kind %0d with none pending", frame_ch.frame_kind));
      end else begin
        want = expected_frames.pop_front();
        if (frame_ch.frame_kind !== want.kind)
          flag_error($sformatf("frame_kind %0d, want %0d", frame_ch.frame_kind, want.kind));
        if (frame_ch.clutch_on !== want.clutch)
          flag_error($sformatf("clutch_on %0b, want %0b", frame_ch.clutch_on, want.clutch));
        if (frame_ch.master_translation !== want.m_trans)
          flag_error($sformatf("master_translation %h, want %h",
                               frame_ch.master_translation, want.m_trans));
        if (frame_ch.master_twist !== want.m_twist)
          flag_error($sformatf("master_twist %h, want %h", frame_ch.master_twist, want.m_twist));
        if (frame_ch.slave_translation !== want.s_trans)
          flag_error($sformatf("slave_translation %h, want %h",
                               frame_ch.slave_translation, want.s_trans));
        if (frame_ch.slave_twist !== want.s_twist)
          flag_error($sformatf("slave_twist %h, want %h", frame_ch.slave_twist, want.s_twist));
      end
    end
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    error_count = 0;
    bytes_sent = 0;
    win_count = 0;
    hold_left = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    for (int i = 0; i < WIN_LEN; i++) win_bytes[i] = 8'd0;
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sync_frame();
    test_clutch_flag();
    test_position_extremes();
    test_output_backpressure();
    test_random_stream(420, 0, 0);
    test_random_stream(420, 45, 0);
    test_random_stream(420, 0, 45);
    test_random_stream(420, 18, 18);

    rx_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/pfp_pkg.sv
hdl/pfp_rx_if.sv
hdl/pfp_frame_if.sv
hdl/pfp_queue.sv
hdl/pfp_front.sv
hdl/pfp_back.sv
hdl/position_frame_parser.sv
verif/tb_top.sv
